@@ sv/blfd_pkg.sv @@
// Shared types and constants for the burst light frame detector.
// Used by every module of the block; depends on nothing.
package blfd_pkg;

    localparam int PIXEL_W   = 8;
    localparam int THRESH_W  = 7;
    localparam int RECOV_W   = 8;
    localparam int FIELD_W   = 22;
    localparam int STATUS_W  = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int PCT_SCALE = 100;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECOVERY   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FOREGROUND = 2'd2;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET  = 7'd30;
    localparam logic [RECOV_W-1:0]  RECOVERY_RESET   = 8'd40;
    localparam logic [PIXEL_W-1:0]  FOREGROUND_RESET = 8'd255;

    // Frame status codes.
    localparam logic [STATUS_W-1:0] ST_NORMAL     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BURST      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RECOV_START = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RECOVERING = 2'd3;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [RECOV_W-1:0]  recovery;
        logic [PIXEL_W-1:0]  foreground;
    } cfg_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  pixel_count;
        logic [FIELD_W-1:0]  white_count;
        logic                suppressed;
        logic [STATUS_W-1:0] frame_status;
    } result_t;

endpackage

@@ sv/burst_light_frame_detector.sv @@
// Top level of the burst light frame detector: configuration registers and
// the front counter, frame queue and back decision stage.
// Depends on blfd_pkg, blfd_front, blfd_queue and blfd_back.
//
//   Channel  Direction  Contents
//   s_*      in         one mask pixel per item, s_tlast on the last pixel
//   m_*      out        one frame result per frame
//   cfg_*    in         register writes, index with data
//
// Pixels are taken at one per clock while s_tready is high. A frame result
// goes from the queue through stage A, where the test product is registered
// before the compare, into the output register, which drives m_*; an output
// register that is not free holds it back. Four finished frames can wait in
// the queue; s_tready falls only when all four are waiting. Reset clears the
// counters, flags and queue and loads the register defaults.
module burst_light_frame_detector
    import blfd_pkg::*;
#(
    parameter int COUNT_BITS = 22
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel
    input  logic                  s_tlast,   // last_of_frame
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [1:0] frame_status, [2] suppressed,
                                             // [24:3] white_count, [46:25] pixel_count
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int REC_W = 2 * COUNT_BITS;

    logic [THRESH_W-1:0] threshold_reg;
    logic [RECOV_W-1:0]  recovery_reg;
    logic [PIXEL_W-1:0]  foreground_reg;
    cfg_t                cfg;

    logic                s_accept;
    logic                push;
    logic [REC_W-1:0]    push_data;
    logic                pop;
    logic [REC_W-1:0]    pop_data;
    logic                q_empty;
    logic                q_full;
    result_t             res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            recovery_reg   <= RECOVERY_RESET;
            foreground_reg <= FOREGROUND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_THRESHOLD:  threshold_reg  <= cfg_wdata[THRESH_W-1:0];
                CFG_RECOVERY:   recovery_reg   <= cfg_wdata;
                CFG_FOREGROUND: foreground_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign cfg.threshold  = threshold_reg;
    assign cfg.recovery   = recovery_reg;
    assign cfg.foreground = foreground_reg;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    blfd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .accept        (s_accept),
        .pixel         (s_tdata),
        .last_of_frame (s_tlast),
        .push          (push),
        .push_data     (push_data)
    );

    blfd_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    blfd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {1'b0, res};

endmodule

@@ sv/blfd_front.sv @@
// Front part: accepts mask pixels and keeps saturating per-frame counts.
// On the last pixel of a frame it pushes both counts into the frame queue.
// Depends on blfd_pkg.
module blfd_front
    import blfd_pkg::*;
#(
    parameter int COUNT_BITS = 22
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    accept,
    input  logic [PIXEL_W-1:0]      pixel,
    input  logic                    last_of_frame,
    output logic                    push,
    output logic [2*COUNT_BITS-1:0] push_data
);

    logic [COUNT_BITS-1:0] fg_cnt_reg;
    logic [COUNT_BITS-1:0] fg_cnt_next;
    logic [COUNT_BITS-1:0] px_cnt_reg;
    logic [COUNT_BITS-1:0] px_cnt_next;
    logic [COUNT_BITS-1:0] px_inc;
    logic [COUNT_BITS-1:0] fg_inc;

    always_comb
    begin
        px_inc = (px_cnt_reg == {COUNT_BITS{1'b1}}) ? px_cnt_reg : px_cnt_reg + 1'b1;
        fg_inc = fg_cnt_reg;
        if (pixel == cfg.foreground && fg_cnt_reg != {COUNT_BITS{1'b1}})
        begin
            fg_inc = fg_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        fg_cnt_next = fg_cnt_reg;
        px_cnt_next = px_cnt_reg;
        if (accept)
        begin
            if (last_of_frame)
            begin
                fg_cnt_next = '0;
                px_cnt_next = '0;
            end
            else
            begin
                fg_cnt_next = fg_inc;
                px_cnt_next = px_inc;
            end
        end
    end

    assign push      = accept && last_of_frame;
    assign push_data = {fg_inc, px_inc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_cnt_reg <= '0;
            px_cnt_reg <= '0;
        end
        else
        begin
            fg_cnt_reg <= fg_cnt_next;
            px_cnt_reg <= px_cnt_next;
        end
    end

endmodule

@@ sv/blfd_queue.sv @@
// Short queue of finished frame counts between the front and back parts.
// Depends on blfd_pkg for its depth.
module blfd_queue
    import blfd_pkg::*;
#(
    parameter int WIDTH = 44
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/blfd_back.sv @@
// Back part: takes frame counts from the queue, runs the burst test and the
// recovery bookkeeping, and holds each frame result in the output register.
// Depends on blfd_pkg.
module blfd_back
    import blfd_pkg::*;
#(
    parameter int COUNT_BITS = 22
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    q_empty,
    input  logic [2*COUNT_BITS-1:0] q_data,
    output logic                    q_pop,
    output logic                    res_valid,
    input  logic                    res_ready,
    output result_t                 res
);

    localparam int PROD_W = COUNT_BITS + THRESH_W;

    // Stage A: products of the test, registered.
    logic                  a_valid_reg;
    logic                  a_valid_next;
    logic [PROD_W-1:0]     a_white_prod_reg;
    logic [PROD_W-1:0]     a_total_prod_reg;
    logic [COUNT_BITS-1:0] a_fg_reg;
    logic [COUNT_BITS-1:0] a_px_reg;
    logic                  a_adv;

    logic [COUNT_BITS-1:0] q_fg;
    logic [COUNT_BITS-1:0] q_px;

    // Frame state.
    logic                  burst_flag_reg;
    logic                  burst_flag_next;
    logic                  recov_flag_reg;
    logic                  recov_flag_next;
    logic [RECOV_W-1:0]    recov_left_reg;
    logic [RECOV_W-1:0]    recov_left_next;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_res_reg;
    result_t               out_res_next;

    logic [STATUS_W-1:0]   status;
    logic                  is_burst;
    logic [FIELD_W-1:0]    white_field;
    logic [FIELD_W-1:0]    pixel_field;

    assign q_fg  = q_data[2*COUNT_BITS-1:COUNT_BITS];
    assign q_px  = q_data[COUNT_BITS-1:0];
    assign a_adv = a_valid_reg && (!out_valid_reg || res_ready);
    assign q_pop = !q_empty && (!a_valid_reg || a_adv);

    generate
        if (COUNT_BITS >= FIELD_W)
        begin : g_field_trunc
            assign white_field = a_fg_reg[FIELD_W-1:0];
            assign pixel_field = a_px_reg[FIELD_W-1:0];
        end
        else
        begin : g_field_ext
            assign white_field = {{(FIELD_W-COUNT_BITS){1'b0}}, a_fg_reg};
            assign pixel_field = {{(FIELD_W-COUNT_BITS){1'b0}}, a_px_reg};
        end
    endgenerate

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (q_pop)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        is_burst        = (a_white_prod_reg >= a_total_prod_reg);
        status          = ST_NORMAL;
        burst_flag_next = burst_flag_reg;
        recov_flag_next = recov_flag_reg;
        recov_left_next = recov_left_reg;
        if (is_burst)
        begin
            burst_flag_next = 1'b1;
            status          = ST_BURST;
        end
        else if (burst_flag_reg)
        begin
            burst_flag_next = 1'b0;
            recov_flag_next = 1'b1;
            recov_left_next = cfg.recovery;
            status          = ST_RECOV_START;
        end
        else if (recov_flag_reg)
        begin
            status = ST_RECOVERING;
            // A count of zero or one ends the recovery on this frame.
            if (recov_left_reg <= RECOV_W'(1))
            begin
                recov_left_next = '0;
                recov_flag_next = 1'b0;
            end
            else
            begin
                recov_left_next = recov_left_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (a_adv)
        begin
            out_valid_next            = 1'b1;
            out_res_next.frame_status = status;
            out_res_next.suppressed   = burst_flag_next || recov_flag_next;
            out_res_next.white_count  = white_field;
            out_res_next.pixel_count  = pixel_field;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_white_prod_reg <= PROD_W'(q_fg) * PROD_W'(PCT_SCALE);
            a_total_prod_reg <= PROD_W'(cfg.threshold) * PROD_W'(q_px);
            a_fg_reg         <= q_fg;
            a_px_reg         <= q_px;
        end
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            burst_flag_reg <= 1'b0;
            recov_flag_reg <= 1'b0;
            recov_left_reg <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            if (a_adv)
            begin
                burst_flag_reg <= burst_flag_next;
                recov_flag_reg <= recov_flag_next;
                recov_left_reg <= recov_left_next;
            end
        end
    end

endmodule
